[hdl/cll_pkg.sv]
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, constants and helpers for the cursor linked list engine.
// ----------------------------------------------------------------------------
package cll_pkg;

   localparam int POOL_DEPTH  = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int IDX_WIDTH   = $clog2(POOL_DEPTH);
   localparam int LINK_WIDTH  = $clog2(POOL_DEPTH + 1);
   localparam int COUNT_WIDTH = $clog2(POOL_DEPTH + 1);

   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [LINK_WIDTH-1:0]  link_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [WORD_WIDTH-1:0]  word_type;
   typedef logic [POOL_DEPTH-1:0]  mask_type;

   localparam link_type NIL_LINK = LINK_WIDTH'(POOL_DEPTH);

   typedef enum logic [2:0] {
      FUNC_INSERT     = 3'd0,
      FUNC_REMOVE     = 3'd1,
      FUNC_STEP_BACK  = 3'd2,
      FUNC_STEP_FWD   = 3'd3,
      FUNC_GO_LAST    = 3'd4,
      FUNC_GO_FIRST   = 3'd5,
      FUNC_READ       = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   function automatic idx_type link_idx(input link_type l);
      return l[IDX_WIDTH-1:0];
   endfunction

   function automatic link_type idx_link(input idx_type i);
      return LINK_WIDTH'(i);
   endfunction

   // sign extend the field, keep the stored width
   function automatic word_type to_word(input logic signed [FIELD_WIDTH-1:0] v);
      logic [2*64-1:0] ext;
      ext = {{(2*64-FIELD_WIDTH){v[FIELD_WIDTH-1]}}, v};
      return ext[WORD_WIDTH-1:0];
   endfunction

   // sign extend the stored word, keep the field width
   function automatic logic [FIELD_WIDTH-1:0] from_word(input word_type w);
      logic [2*64-1:0] ext;
      ext = {{(2*64-WORD_WIDTH){w[WORD_WIDTH-1]}}, w};
      return ext[FIELD_WIDTH-1:0];
   endfunction

endpackage

[hdl/cll_ctrl.sv]
// ----------------------------------------------------------------------------
// cll_ctrl
// Sequencer: capture a request, execute it, hold the response until taken.
// ----------------------------------------------------------------------------
module cll_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cll_pkg::dp_cmd_type dp_cmd
);

   import cll_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            dp_cmd.execute = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/cll_datapath.sv]
// ----------------------------------------------------------------------------
// cll_datapath
// Node pool, links, end pointers, cursor and response register.
// ----------------------------------------------------------------------------
module cll_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cll_pkg::dp_cmd_type                    dp_cmd,
   input  logic [2:0]                             req_func,
   input  logic signed [cll_pkg::FIELD_WIDTH-1:0] req_value,
   output logic signed [cll_pkg::FIELD_WIDTH-1:0] rsp_word_out,
   output logic                                   rsp_ok,
   output logic                                   rsp_is_empty
);

   import cll_pkg::*;

   logic [2:0]                    func_ff;
   logic signed [FIELD_WIDTH-1:0] value_ff;

   word_type  node_ff [POOL_DEPTH];
   link_type  prev_ff [POOL_DEPTH];
   link_type  next_ff [POOL_DEPTH];
   link_type  prev_in [POOL_DEPTH];
   link_type  next_in [POOL_DEPTH];

   mask_type  free_ff,   free_in;
   link_type  cursor_ff, cursor_in;
   link_type  first_ff,  first_in;
   link_type  last_ff,   last_in;
   count_type count_ff,  count_in;

   logic [FIELD_WIDTH-1:0] word_ff, word_in;
   logic                   ok_ff, ok_in;
   logic                   empty_ff;

   logic     node_we;
   idx_type  node_widx;
   idx_type  alloc_idx;
   idx_type  cur_idx;
   link_type cur_prev;
   link_type cur_next;
   logic     has;
   logic     full;

   assign has      = cursor_ff != NIL_LINK;
   assign full     = count_ff == COUNT_WIDTH'(POOL_DEPTH);
   assign cur_idx  = link_idx(cursor_ff);
   assign cur_prev = prev_ff[cur_idx];
   assign cur_next = next_ff[cur_idx];

   always_comb begin
      alloc_idx = '0;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            alloc_idx = IDX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      prev_in   = prev_ff;
      next_in   = next_ff;
      free_in   = free_ff;
      cursor_in = cursor_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      word_in   = '0;
      ok_in     = 1'b0;
      node_we   = 1'b0;
      node_widx = alloc_idx;
      case (func_type'(func_ff))
         FUNC_INSERT: begin
            if (!full) begin
               node_we            = 1'b1;
               free_in[alloc_idx] = 1'b0;
               if (!has) begin
                  prev_in[alloc_idx] = NIL_LINK;
                  next_in[alloc_idx] = NIL_LINK;
                  first_in           = idx_link(alloc_idx);
                  last_in            = idx_link(alloc_idx);
               end else begin
                  prev_in[alloc_idx] = cursor_ff;
                  next_in[alloc_idx] = cur_next;
                  next_in[cur_idx]   = idx_link(alloc_idx);
                  if (cur_next != NIL_LINK) begin
                     prev_in[link_idx(cur_next)] = idx_link(alloc_idx);
                  end else begin
                     last_in = idx_link(alloc_idx);
                  end
               end
               cursor_in = idx_link(alloc_idx);
               count_in  = count_ff + 1'b1;
               ok_in     = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (has) begin
               word_in = from_word(node_ff[cur_idx]);
               if (cur_prev != NIL_LINK) begin
                  next_in[link_idx(cur_prev)] = cur_next;
               end else begin
                  first_in = cur_next;
               end
               if (cur_next != NIL_LINK) begin
                  prev_in[link_idx(cur_next)] = cur_prev;
               end else begin
                  last_in = cur_prev;
               end
               free_in[cur_idx] = 1'b1;
               cursor_in = (cur_prev != NIL_LINK) ? cur_prev : cur_next;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
               ok_in = 1'b1;
            end
         end
         FUNC_STEP_BACK: begin
            if (has && cur_prev != NIL_LINK) begin
               cursor_in = cur_prev;
               ok_in     = 1'b1;
            end
         end
         FUNC_STEP_FWD: begin
            if (has && cur_next != NIL_LINK) begin
               cursor_in = cur_next;
               ok_in     = 1'b1;
            end
         end
         FUNC_GO_LAST: begin
            if (has) begin
               cursor_in = last_ff;
               ok_in     = 1'b1;
            end
         end
         FUNC_GO_FIRST: begin
            if (has) begin
               cursor_in = first_ff;
               ok_in     = 1'b1;
            end
         end
         FUNC_READ: begin
            if (has) begin
               word_in = from_word(node_ff[cur_idx]);
               ok_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (dp_cmd.execute) begin
         prev_ff  <= prev_in;
         next_ff  <= next_in;
         word_ff  <= word_in;
         ok_ff    <= ok_in;
         empty_ff <= cursor_in == NIL_LINK;
         if (node_we) begin
            node_ff[node_widx] <= to_word(value_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff   <= '1;
         cursor_ff <= NIL_LINK;
         first_ff  <= NIL_LINK;
         last_ff   <= NIL_LINK;
         count_ff  <= '0;
      end else if (dp_cmd.execute) begin
         free_ff   <= free_in;
         cursor_ff <= cursor_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_word_out = word_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_is_empty = empty_ff;

endmodule

[hdl/cursor_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Doubly linked list of signed words in a fixed node pool, with a cursor.
//
//   Channel   Ports                                   Role
//   req       req_valid req_stall req_func req_value  operation in
//   rsp       rsp_valid rsp_stall rsp_word_out        result out
//             rsp_ok rsp_is_empty
//
// One transfer in gives exactly one transfer out.
// An operation runs through capture, execute and respond in turn; a new
// request is taken only after the previous response transfer completes.
// The execute cycle does all link and pointer updates in one step.
// req_stall is high from the execute step until the response transfer completes.
// Synchronous reset empties the pool and clears the cursor and end pointers.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [2:0]                             req_func,
   input  logic signed [cll_pkg::FIELD_WIDTH-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cll_pkg::FIELD_WIDTH-1:0] rsp_word_out,
   output logic                                   rsp_ok,
   output logic                                   rsp_is_empty
);

   import cll_pkg::*;

   dp_cmd_type dp_cmd;

   cll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   cll_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_word_out (rsp_word_out),
      .rsp_ok       (rsp_ok),
      .rsp_is_empty (rsp_is_empty)
   );

endmodule

[hdl/cll_checker.sv]
// ----------------------------------------------------------------------------
// cll_checker
// Port-level checks on request/response sequencing of the list engine.
// ----------------------------------------------------------------------------
module cll_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [cll_pkg::FIELD_WIDTH-1:0] rsp_word_out,
   input logic                                   rsp_ok,
   input logic                                   rsp_is_empty
);

   logic req_xfer;
   assign req_xfer = req_valid && !req_stall;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("request taken while previous one in flight");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##2 rsp_valid)
      else $error("response missing two cycles after request transfer");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while response pending");

   a_fail_zero_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_word_out == '0)
      else $error("failed operation returned nonzero word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_out)
         && $stable(rsp_ok) && $stable(rsp_is_empty))
      else $error("stalled response changed");

endmodule

bind cursor_linked_list_engine_core cll_checker u_cll_checker (.*);
